// File: hdl/soat_pkg.sv
package soat_pkg;

  localparam int ORD_W = 30;
  localparam int OFF_W = 48;
  localparam int NODE_W = 16;
  localparam int CNT_W = 5;
  localparam int IDX_W = 4;
  localparam int MAX_SHARDS = 16;

  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_FORWARD = 2'd1,
    FUNC_REVERSE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [0:0] {
    REG_NODE_TOTAL  = 1'd0,
    REG_ENTRY_LIMIT = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FWD_SCAN,
    ST_FWD_READ,
    ST_FWD_MUL,
    ST_FWD_CHECK,
    ST_REV_READ,
    ST_REV_PREP,
    ST_REV_DIV,
    ST_REV_CHECK,
    ST_FAIL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic scan_clear;
    logic scan_step;
    logic read_fwd;
    logic read_rev;
    logic mul_step;
    logic fwd_check;
    logic rev_prep;
    logic div_step;
    logic rev_check;
    logic fail;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  load_ok;
    logic  fwd_pre_ok;
    logic  scan_done;
    logic  found;
    logic  mul_done;
    logic  rev_pre_ok;
    logic  div_done;
    logic  out_taken;
  } stat_t;

endpackage

// File: hdl/soat_if.sv
interface soat_in_if;
  logic valid;
  logic ready;
  soat_pkg::func_t func;
  logic [soat_pkg::IDX_W-1:0] entry_index;
  logic [soat_pkg::ORD_W-1:0] entry_ordinal_base;
  logic [soat_pkg::ORD_W-1:0] entry_node_count;
  logic [soat_pkg::OFF_W-1:0] entry_base_offset;
  logic [soat_pkg::OFF_W-1:0] entry_stride;
  logic [soat_pkg::NODE_W-1:0] entry_memory_node;
  logic [soat_pkg::ORD_W-1:0] query_ordinal;
  logic [soat_pkg::NODE_W-1:0] query_node;
  logic [soat_pkg::OFF_W-1:0] query_offset;
  modport source (output valid, func, entry_index, entry_ordinal_base, entry_node_count,
    entry_base_offset, entry_stride, entry_memory_node, query_ordinal, query_node,
    query_offset, input ready);
  modport sink (input valid, func, entry_index, entry_ordinal_base, entry_node_count,
    entry_base_offset, entry_stride, entry_memory_node, query_ordinal, query_node,
    query_offset, output ready);
endinterface

interface soat_out_if;
  logic valid;
  logic ready;
  logic ok;
  logic [soat_pkg::ORD_W-1:0] result_ordinal;
  logic [soat_pkg::NODE_W-1:0] result_node;
  logic [soat_pkg::OFF_W-1:0] result_offset;
  modport source (output valid, ok, result_ordinal, result_node, result_offset, input ready);
  modport sink (input valid, ok, result_ordinal, result_node, result_offset, output ready);
endinterface

interface soat_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/soat_ctrl.sv
module soat_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  soat_pkg::stat_t stat,
  output soat_pkg::cmd_t cmd,
  output logic in_ready
);

  soat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= soat_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      soat_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = soat_pkg::ST_LOAD;
        end
      end
      soat_pkg::ST_LOAD: begin
        unique case (stat.func)
          soat_pkg::FUNC_LOAD: begin
            if (stat.load_ok) begin
              cmd.load = 1'b1;
              state_next = soat_pkg::ST_OUT;
            end else state_next = soat_pkg::ST_FAIL;
          end
          soat_pkg::FUNC_FORWARD: begin
            cmd.scan_clear = 1'b1;
            state_next = stat.fwd_pre_ok ? soat_pkg::ST_FWD_SCAN : soat_pkg::ST_FAIL;
          end
          soat_pkg::FUNC_REVERSE: state_next = soat_pkg::ST_REV_READ;
          default: state_next = soat_pkg::ST_FAIL;
        endcase
      end
      soat_pkg::ST_FWD_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done)
          state_next = stat.found ? soat_pkg::ST_FWD_READ : soat_pkg::ST_FAIL;
      end
      soat_pkg::ST_FWD_READ: begin
        cmd.read_fwd = 1'b1;
        state_next = soat_pkg::ST_FWD_MUL;
      end
      soat_pkg::ST_FWD_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_done) state_next = soat_pkg::ST_FWD_CHECK;
      end
      soat_pkg::ST_FWD_CHECK: begin
        cmd.fwd_check = 1'b1;
        state_next = soat_pkg::ST_OUT;
      end
      soat_pkg::ST_REV_READ: begin
        if (stat.rev_pre_ok) begin
          cmd.read_rev = 1'b1;
          state_next = soat_pkg::ST_REV_PREP;
        end else state_next = soat_pkg::ST_FAIL;
      end
      soat_pkg::ST_REV_PREP: begin
        cmd.rev_prep = 1'b1;
        state_next = soat_pkg::ST_REV_DIV;
      end
      soat_pkg::ST_REV_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = soat_pkg::ST_REV_CHECK;
      end
      soat_pkg::ST_REV_CHECK: begin
        cmd.rev_check = 1'b1;
        state_next = soat_pkg::ST_OUT;
      end
      soat_pkg::ST_FAIL: begin
        cmd.fail = 1'b1;
        state_next = soat_pkg::ST_OUT;
      end
      soat_pkg::ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (stat.out_taken) state_next = soat_pkg::ST_IDLE;
      end
      default: state_next = soat_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/soat_dp.sv
module soat_dp (
  input  logic clk,
  input  logic rst,
  soat_in_if.sink  in_ch,
  soat_out_if.source out_ch,
  soat_cfg_if.sink cfg,
  input  soat_pkg::cmd_t cmd,
  output soat_pkg::stat_t stat
);

  localparam int NS = soat_pkg::MAX_SHARDS;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int OW = soat_pkg::OFF_W;
  localparam int RW = soat_pkg::ORD_W;
  localparam int PW = OW + RW;
  localparam int MB = 8;
  localparam int MSTEPS = (RW + MB - 1) / MB;
  localparam logic [OW-1:0] OFF_LIM = '1;
  localparam logic [32:0] ORD_LIM = 33'd1 << RW;
  localparam logic [soat_pkg::CNT_W-1:0] MAXC = soat_pkg::CNT_W'(NS);

  logic [soat_pkg::ORD_W-1:0] node_total;
  logic [soat_pkg::CNT_W-1:0] entry_limit;

  logic [RW-1:0] m_first [NS];
  logic [RW-1:0] m_size  [NS];
  logic [OW-1:0] m_base  [NS];
  logic [OW-1:0] m_stride[NS];
  logic [soat_pkg::NODE_W-1:0] m_home[NS];

  soat_pkg::func_t func;
  logic [soat_pkg::IDX_W-1:0] e_idx;
  logic [RW-1:0] e_first, e_size, q_ord;
  logic [OW-1:0] e_base, e_stride, q_off;
  logic [soat_pkg::NODE_W-1:0] e_home, q_node;

  logic [soat_pkg::CNT_W-1:0] in_use, scan_i;
  logic [SW-1:0] found_i;
  logic found;
  logic [RW-1:0] r_first, r_size;
  logic [OW-1:0] r_base, r_stride;
  logic [soat_pkg::NODE_W-1:0] r_home;
  logic [RW-1:0] slot;
  logic [PW-1:0] prod;
  logic [3:0] mcnt;
  logic [OW-1:0] rem, quo;
  logic [6:0] dcnt;
  logic rev_bad;
  logic ok;
  logic [RW-1:0] res_ord;
  logic [soat_pkg::NODE_W-1:0] res_node;
  logic [OW-1:0] res_off;

  assign cfg.ready = 1'b1;
  assign in_use = (entry_limit > MAXC) ? MAXC : entry_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_total <= '0;
      entry_limit <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        soat_pkg::REG_NODE_TOTAL: node_total <= cfg.data[soat_pkg::ORD_W-1:0];
        soat_pkg::REG_ENTRY_LIMIT: entry_limit <= cfg.data[soat_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func <= in_ch.func;
      e_idx <= in_ch.entry_index;
      e_first <= in_ch.entry_ordinal_base;
      e_size <= in_ch.entry_node_count;
      e_base <= in_ch.entry_base_offset;
      e_stride <= in_ch.entry_stride;
      e_home <= in_ch.entry_memory_node;
      q_ord <= in_ch.query_ordinal;
      q_node <= in_ch.query_node;
      q_off <= in_ch.query_offset;
    end
  end

  // table memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_first[e_idx[SW-1:0]] <= e_first;
      m_size[e_idx[SW-1:0]] <= e_size;
      m_base[e_idx[SW-1:0]] <= e_base;
      m_stride[e_idx[SW-1:0]] <= e_stride;
      m_home[e_idx[SW-1:0]] <= e_home;
    end
    if (cmd.scan_step) r_first <= m_first[scan_i[SW-1:0]];
    if (cmd.read_fwd || cmd.read_rev) begin
      r_first <= m_first[cmd.read_fwd ? found_i : q_node[SW-1:0]];
      r_size <= m_size[cmd.read_fwd ? found_i : q_node[SW-1:0]];
      r_base <= m_base[cmd.read_fwd ? found_i : q_node[SW-1:0]];
      r_stride <= m_stride[cmd.read_fwd ? found_i : q_node[SW-1:0]];
      r_home <= m_home[cmd.read_fwd ? found_i : q_node[SW-1:0]];
    end
  end

  // scan: read entry i, compare it in the next cycle; scan_i leads by one
  logic scan_vld;
  logic [SW-1:0] scan_prev;
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_i <= '0;
      scan_vld <= 1'b0;
      found <= 1'b0;
      found_i <= '0;
    end else if (cmd.scan_step) begin
      if (scan_i < in_use) scan_i <= scan_i + 1'b1;
      scan_vld <= scan_i < in_use;
      scan_prev <= scan_i[SW-1:0];
      if (scan_vld && r_first <= q_ord) begin
        found <= 1'b1;
        found_i <= scan_prev;
      end
    end
  end

  assign slot = q_ord - r_first;

  // shift-add multiply, MB bits of slot per cycle
  logic [RW-1:0] mslot;
  always_ff @(posedge clk) begin
    if (cmd.read_fwd) mcnt <= '0;
    else if (cmd.mul_step) begin
      if (mcnt == 4'd0) begin
        prod <= PW'(r_stride * slot[MB-1:0]);
        mslot <= slot >> MB;
      end else begin
        prod <= prod + (PW'(r_stride * mslot[MB-1:0]) << (MB * int'(mcnt)));
        mslot <= mslot >> MB;
      end
      mcnt <= mcnt + 4'd1;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [OW:0] trial;
  assign trial = {rem, quo[OW-1]} - {1'b0, r_stride};
  always_ff @(posedge clk) begin
    if (cmd.rev_prep) begin
      rem <= '0;
      quo <= q_off - r_base;
      dcnt <= '0;
      rev_bad <= (q_off < r_base) || (r_stride == '0);
    end else if (cmd.div_step) begin
      if (!trial[OW]) begin
        rem <= trial[OW-1:0];
        quo <= {quo[OW-2:0], 1'b1};
      end else begin
        rem <= {rem[OW-2:0], quo[OW-1]};
        quo <= {quo[OW-2:0], 1'b0};
      end
      dcnt <= dcnt + 7'd1;
    end
  end

  logic [PW:0] fwd_sum;
  logic [32:0] rev_tot;
  assign fwd_sum = {1'b0, PW'(r_base)} + {1'b0, prod};
  assign rev_tot = 33'(r_first) + 33'(quo);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ok <= 1'b0;
      res_ord <= '0;
      res_node <= '0;
      res_off <= '0;
    end else if (cmd.load) ok <= 1'b1;
    else if (cmd.fail) ok <= 1'b0;
    else if (cmd.fwd_check) begin
      if (slot < r_size && r_base <= OFF_LIM && fwd_sum <= (PW + 1)'(OFF_LIM)) begin
        ok <= 1'b1;
        res_node <= r_home;
        res_off <= fwd_sum[OW-1:0];
      end
    end else if (cmd.rev_check) begin
      if (!rev_bad && rem == '0 && quo < OW'(r_size) && rev_tot < ORD_LIM) begin
        ok <= 1'b1;
        res_ord <= rev_tot[RW-1:0];
      end
    end
  end

  assign out_ch.valid = cmd.out_valid;
  assign out_ch.ok = ok;
  assign out_ch.result_ordinal = res_ord;
  assign out_ch.result_node = res_node;
  assign out_ch.result_offset = res_off;

  assign stat.func = func;
  assign stat.load_ok = 32'(e_idx) < NS;
  assign stat.fwd_pre_ok = q_ord < node_total;
  assign stat.scan_done = !scan_vld && (scan_i >= in_use) && scan_i != 0 || in_use == 0;
  assign stat.found = found;
  assign stat.mul_done = mcnt == 4'(MSTEPS - 1);
  assign stat.rev_pre_ok = !(q_node == '0 && q_off == '0) && (q_node < 16'(in_use));
  assign stat.div_done = dcnt == 7'(OW - 1);
  assign stat.out_taken = out_ch.ready;

endmodule

// File: hdl/shard_ordinal_address_translator.sv
// channel  dir  payload
// in_ch    in   func, entry_*, query_*
// out_ch   out  ok, result_ordinal, result_node, result_offset
// cfg      in   index, data (node_total, entry limit)
// One item at a time. Forward scans the entries in use, then runs a 4-step multiply.
// Reverse runs the one-bit-per-cycle 48-bit divider. Items rejected by the early
// checks skip the multiply or divide. rst is synchronous and clears control and config.
// The result holds in the output register until out_ch.ready.
module shard_ordinal_address_translator (
  input logic clk,
  input logic rst,
  soat_in_if.sink in_ch,
  soat_out_if.source out_ch,
  soat_cfg_if.sink cfg
);

  soat_pkg::cmd_t cmd;
  soat_pkg::stat_t stat;

  soat_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .stat, .cmd, .in_ready(in_ch.ready)
  );

  soat_dp u_dp (
    .clk, .rst, .in_ch, .out_ch, .cfg, .cmd, .stat
  );

endmodule

// File: hdl/soat_checker.sv
module soat_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic ok,
  input logic [soat_pkg::ORD_W-1:0] result_ordinal,
  input logic [soat_pkg::NODE_W-1:0] result_node
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> result_ordinal == '0 && result_node == '0)
    else $error("failed result not zero");
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_ordinal == '0 || result_node == '0)
    else $error("both result kinds set");
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind shard_ordinal_address_translator soat_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .ok(out_ch.ok),
  .result_ordinal(out_ch.result_ordinal), .result_node(out_ch.result_node)
);

// File: dv/soat_tb_if.sv
`timescale 1ns / 100ps
// Channel interfaces come from the RTL (hdl/soat_if.sv); this file only holds
// shared testbench record types for requests and responses.
package soat_tb_pkg;

  typedef struct packed {
    soat_pkg::func_t func;
    logic [soat_pkg::IDX_W-1:0] idx;
    logic [soat_pkg::ORD_W-1:0] ord_base;
    logic [soat_pkg::ORD_W-1:0] cnt;
    logic [soat_pkg::OFF_W-1:0] boff;
    logic [soat_pkg::OFF_W-1:0] stride;
    logic [soat_pkg::NODE_W-1:0] mnode;
    logic [soat_pkg::ORD_W-1:0] q_ord;
    logic [soat_pkg::NODE_W-1:0] q_node;
    logic [soat_pkg::OFF_W-1:0] q_off;
  } xlat_req_t;

  typedef struct packed {
    logic ok;
    logic [soat_pkg::ORD_W-1:0] ordinal;
    logic [soat_pkg::NODE_W-1:0] node;
    logic [soat_pkg::OFF_W-1:0] offset;
  } xlat_rsp_t;
endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int ORD_W = soat_pkg::ORD_W;
  localparam int OFF_W = soat_pkg::OFF_W;
  localparam int NODE_W = soat_pkg::NODE_W;
  localparam int CNT_W = soat_pkg::CNT_W;
  localparam int IDX_W = soat_pkg::IDX_W;
  localparam int SHARDS = 16;
  localparam int WATCHDOG = 20000;
  localparam int RANDOM_ITEMS = 630;
  localparam logic [OFF_W-1:0] OFF_MAX = '1;
  localparam logic [ORD_W-1:0] ORD_MAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  soat_in_if in_ch();
  soat_out_if out_ch();
  soat_cfg_if cfg();

  shard_ordinal_address_translator i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block's table and registers
  logic [ORD_W-1:0] tbl_first [SHARDS];
  logic [ORD_W-1:0] tbl_size [SHARDS];
  logic [OFF_W-1:0] tbl_base [SHARDS];
  logic [OFF_W-1:0] tbl_stride [SHARDS];
  logic [NODE_W-1:0] tbl_home [SHARDS];
  bit tbl_loaded [SHARDS];
  logic [ORD_W-1:0] node_total_q;
  logic [CNT_W-1:0] entry_limit_q;

  soat_tb_pkg::xlat_rsp_t pending_rsp[$];
  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int n_fwd_ok = 0, n_rev_ok = 0, n_fail = 0;
  bit no_gaps = 1'b0;
  int hold_cycles = 0;

  function automatic int used_entries();
    return (entry_limit_q > SHARDS) ? SHARDS : int'(entry_limit_q);
  endfunction

  function automatic soat_tb_pkg::xlat_rsp_t translate(soat_tb_pkg::xlat_req_t r);
    soat_tb_pkg::xlat_rsp_t o;
    int hit;
    logic [63:0] slot, rel, lim, prod, tot;
    o = '{1'b0, '0, '0, '0};
    hit = -1;
    case (r.func)
      soat_pkg::FUNC_LOAD: begin
        tbl_first[r.idx] = r.ord_base;
        tbl_size[r.idx] = r.cnt;
        tbl_base[r.idx] = r.boff;
        tbl_stride[r.idx] = r.stride;
        tbl_home[r.idx] = r.mnode;
        tbl_loaded[r.idx] = 1'b1;
        o.ok = 1'b1;
      end
      soat_pkg::FUNC_FORWARD: begin
        if (r.q_ord < node_total_q) begin
          for (int i = 0; i < used_entries(); i++)
            if (tbl_first[i] <= r.q_ord) hit = i;
          if (hit >= 0) begin
            slot = 64'(r.q_ord) - 64'(tbl_first[hit]);
            lim = 64'(OFF_MAX);
            if (slot < 64'(tbl_size[hit]) && (tbl_stride[hit] == 0 ||
                slot <= (lim - 64'(tbl_base[hit])) / 64'(tbl_stride[hit]))) begin
              prod = slot * 64'(tbl_stride[hit]);
              o.ok = 1'b1;
              o.node = tbl_home[hit];
              o.offset = OFF_W'(64'(tbl_base[hit]) + prod);
            end
          end
        end
      end
      soat_pkg::FUNC_REVERSE: begin
        if (!(r.q_node == 0 && r.q_off == 0) && r.q_node < used_entries()) begin
          if (r.q_off >= tbl_base[r.q_node] && tbl_stride[r.q_node] != 0) begin
            rel = 64'(r.q_off) - 64'(tbl_base[r.q_node]);
            if (rel % 64'(tbl_stride[r.q_node]) == 0) begin
              slot = rel / 64'(tbl_stride[r.q_node]);
              tot = 64'(tbl_first[r.q_node]) + slot;
              if (slot < 64'(tbl_size[r.q_node]) && tot < (64'd1 << ORD_W)) begin
                o.ok = 1'b1;
                o.ordinal = ORD_W'(tot);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // only entries loaded since reset may be read
  function automatic bit safe_to_send(soat_tb_pkg::xlat_req_t r);
    int n;
    n = used_entries();
    if (r.func == soat_pkg::FUNC_FORWARD) begin
      if (r.q_ord >= node_total_q) return 1'b1;
      for (int i = 0; i < n; i++)
        if (!tbl_loaded[i]) return 1'b0;
      return 1'b1;
    end
    if (r.func == soat_pkg::FUNC_REVERSE) begin
      if (r.q_node == 0 && r.q_off == 0) return 1'b1;
      if (r.q_node >= n) return 1'b1;
      return tbl_loaded[r.q_node];
    end
    return 1'b1;
  endfunction

  task automatic write_reg(soat_pkg::reg_idx_t ri, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= ri;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    if (ri == soat_pkg::REG_NODE_TOTAL) node_total_q = val[ORD_W-1:0];
    else entry_limit_q = val[CNT_W-1:0];
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // expected is decided at the transfer, in order of acceptance
  task automatic send(soat_tb_pkg::xlat_req_t r);
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.entry_index <= r.idx;
    in_ch.entry_ordinal_base <= r.ord_base;
    in_ch.entry_node_count <= r.cnt;
    in_ch.entry_base_offset <= r.boff;
    in_ch.entry_stride <= r.stride;
    in_ch.entry_memory_node <= r.mnode;
    in_ch.query_ordinal <= r.q_ord;
    in_ch.query_node <= r.q_node;
    in_ch.query_offset <= r.q_off;
    do @(posedge clk); while (!in_ch.ready);
    pending_rsp.insert(pending_rsp.size(), translate(r));
    accepted++;
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic soat_tb_pkg::xlat_req_t blank(soat_pkg::func_t f);
    soat_tb_pkg::xlat_req_t r;
    r = '{f, '0, '0, '0, '0, '0, '0, '0, '0, '0};
    return r;
  endfunction

  function automatic soat_tb_pkg::xlat_req_t load(int i, logic [ORD_W-1:0] fb,
                                                  logic [ORD_W-1:0] c,
                                                  logic [OFF_W-1:0] b, logic [OFF_W-1:0] s,
                                                  logic [NODE_W-1:0] h);
    soat_tb_pkg::xlat_req_t r;
    r = blank(soat_pkg::FUNC_LOAD);
    r.idx = IDX_W'(i); r.ord_base = fb; r.cnt = c; r.boff = b; r.stride = s; r.mnode = h;
    return r;
  endfunction

  function automatic soat_tb_pkg::xlat_req_t fwd(logic [ORD_W-1:0] q);
    soat_tb_pkg::xlat_req_t r;
    r = blank(soat_pkg::FUNC_FORWARD);
    r.q_ord = q;
    return r;
  endfunction

  function automatic soat_tb_pkg::xlat_req_t rev(logic [NODE_W-1:0] n, logic [OFF_W-1:0] o);
    soat_tb_pkg::xlat_req_t r;
    r = blank(soat_pkg::FUNC_REVERSE);
    r.q_node = n; r.q_off = o;
    return r;
  endfunction

  function automatic soat_tb_pkg::xlat_req_t rand_item();
    soat_tb_pkg::xlat_req_t r;
    int k, e;
    logic [63:0] slot;
    r = blank(soat_pkg::func_t'($urandom_range(0, 3)));
    k = $urandom_range(0, 9);
    r.idx = IDX_W'($urandom);
    r.ord_base = (k < 5) ? ORD_W'($urandom_range(0, 4000)) : ORD_W'($urandom);
    r.cnt = (k < 5) ? ORD_W'($urandom_range(0, 600)) : ORD_W'($urandom);
    r.boff = (k < 3) ? OFF_W'($urandom_range(0, 100000))
                     : {16'($urandom), 32'($urandom)};
    r.stride = (k < 6) ? OFF_W'($urandom_range(0, 256)) : {16'($urandom), 32'($urandom)};
    r.mnode = NODE_W'($urandom);
    r.q_ord = (k < 7) ? ORD_W'($urandom_range(0, 5000)) : ORD_W'($urandom);
    r.q_node = (k < 7) ? NODE_W'($urandom_range(0, 17)) : NODE_W'($urandom);
    r.q_off = {16'($urandom), 32'($urandom)};
    // mostly well-formed reverse queries aimed at a real slot
    e = int'(r.q_node[3:0]);
    if (r.func == soat_pkg::FUNC_REVERSE && k < 7 && tbl_loaded[e]) begin
      r.q_node = NODE_W'(e);
      slot = 64'($urandom_range(0, 700));
      r.q_off = OFF_W'(64'(tbl_base[e]) + slot * 64'(tbl_stride[e]) +
                       (k == 0 ? 64'd1 : 64'd0));
    end
    if (r.func == soat_pkg::FUNC_FORWARD && k < 5 && tbl_loaded[r.idx])
      r.q_ord = tbl_first[r.idx] + ORD_W'($urandom_range(0, 700));
    return r;
  endfunction

  // result side: random stall bursts plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (!no_gaps && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    soat_tb_pkg::xlat_rsp_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_rsp.size() == 0) begin
        $error("result transfer with no expectation waiting");
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (out_ch.ok !== want.ok) begin
          $error("ok: expected %0d actual %0d", want.ok, out_ch.ok); errors++;
        end
        if (out_ch.result_ordinal !== want.ordinal) begin
          $error("result_ordinal: expected %0h actual %0h", want.ordinal,
                 out_ch.result_ordinal); errors++;
        end
        if (out_ch.result_node !== want.node) begin
          $error("result_node: expected %0h actual %0h", want.node,
                 out_ch.result_node); errors++;
        end
        if (out_ch.result_offset !== want.offset) begin
          $error("result_offset: expected %0h actual %0h", want.offset,
                 out_ch.result_offset); errors++;
        end
        if (want.ok && want.node != 0 || want.ok && want.offset != 0) n_fwd_ok++;
        if (want.ok && want.ordinal != 0) n_rev_ok++;
        if (!want.ok) n_fail++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  soat_tb_pkg::xlat_req_t plan [$];
  soat_tb_pkg::xlat_rsp_t typed_rsp [$];

  initial begin
    soat_tb_pkg::xlat_req_t r;
    soat_tb_pkg::xlat_rsp_t got;
    in_ch.valid = 1'b0;
    in_ch.func = soat_pkg::FUNC_NONE;
    in_ch.entry_index = '0;
    in_ch.entry_ordinal_base = '0;
    in_ch.entry_node_count = '0;
    in_ch.entry_base_offset = '0;
    in_ch.entry_stride = '0;
    in_ch.entry_memory_node = '0;
    in_ch.query_ordinal = '0;
    in_ch.query_node = '0;
    in_ch.query_offset = '0;
    cfg.valid = 1'b0;
    cfg.index = soat_pkg::REG_NODE_TOTAL;
    cfg.data = '0;
    node_total_q = '0;
    entry_limit_q = '0;
    foreach (tbl_loaded[i]) tbl_loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset: node_total 0 so forward fails, no entries so reverse fails
    plan = '{fwd(0), rev(0, 0), rev(1, 8), blank(soat_pkg::FUNC_NONE)};
    typed_rsp = '{'{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0}};
    foreach (plan[i]) begin
      got = translate(plan[i]);
      if (got != typed_rsp[i]) begin
        $error("directed table row %0d disagrees with typed result", i); errors++;
      end
      pending_rsp.insert(pending_rsp.size(), typed_rsp[i]);
      // translate already queued nothing; send without re-predicting
      in_ch.valid <= 1'b1;
      in_ch.func <= plan[i].func;
      in_ch.query_ordinal <= plan[i].q_ord;
      in_ch.query_node <= plan[i].q_node;
      in_ch.query_offset <= plan[i].q_off;
      do @(posedge clk); while (!in_ch.ready);
      accepted++;
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
    drain();

    write_reg(soat_pkg::REG_NODE_TOTAL, 32'(ORD_MAX));
    write_reg(soat_pkg::REG_ENTRY_LIMIT, 32'd4);
    // directed: extremes, every func, each special case
    plan = '{
      load(0, 0, 10, 0, 16, 16'h0001),
      load(1, 10, 5, 1000, 0, 16'hFFFF),
      load(2, 100, ORD_MAX, OFF_MAX - 100, 10, 16'h8000),
      load(3, ORD_MAX - 2, 4, 48'h1000, OFF_MAX, 16'h1234),
      fwd(0), fwd(9), fwd(10), fwd(14), fwd(15), fwd(50),
      fwd(100 + 10), fwd(100 + 11), fwd(ORD_MAX - 2), fwd(ORD_MAX - 1),
      rev(0, 0), rev(0, 32), rev(0, 33), rev(1, 1000), rev(2, OFF_MAX - 100),
      rev(3, 48'h1000), rev(4, 16), rev(16'hFFFF, OFF_MAX),
      blank(soat_pkg::FUNC_NONE)};
    foreach (plan[i]) send(plan[i]);
    in_ch.valid <= 1'b0;
    drain();
    // load beyond the table is impossible with a 4-bit index; oversized count
    write_reg(soat_pkg::REG_ENTRY_LIMIT, 32'd31);
    for (int i = 4; i < SHARDS; i++)
      send(load(i, ORD_W'(i * 1000), 900, OFF_W'(i * 100000), OFF_W'(i * 8), NODE_W'(i)));
    send(fwd(15500));
    send(rev(15, 1500000 + 8 * 3));
    in_ch.valid <= 1'b0;
    drain();

    // random phases across register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(soat_pkg::REG_NODE_TOTAL, (ph == 1) ? 32'd0 :
                (ph == 2) ? 32'(ORD_MAX) : 32'($urandom_range(100, 20000)));
      write_reg(soat_pkg::REG_ENTRY_LIMIT, (ph == 3) ? 32'd0 : (ph == 4) ? 32'd16
                : 32'($urandom_range(1, 31)));
      if (ph == 4) no_gaps = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / 5; n++) begin
        r = rand_item();
        if (!safe_to_send(r)) r = blank(soat_pkg::FUNC_NONE);
        if (ph == 2 && n == 20) begin
          hold_cycles = 600;
        end
        if (ph == 3 && n == 60) begin
          in_ch.valid <= 1'b0;
          while (pending_rsp.size() != 0) @(negedge clk);
          @(negedge clk);
        end
        send(r);
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    $display("Sent %0d items, %0d results checked", accepted, results_seen);
    $display("(%0d forward hits, %0d reverse hits, %0d fails).",
             n_fwd_ok, n_rev_ok, n_fail);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
